>>> rtl/recorder_link_line_decoder_top_assert.svh
// Assertion helpers for the line decoder top level.
`ifndef RECORDER_LINK_LINE_DECODER_TOP_ASSERT_SVH
`define RECORDER_LINK_LINE_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define RLLD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rlld_pkg.sv
package rlld_pkg;

  localparam int MAX_LINE = 255;
  localparam int CIL_W    = $clog2(MAX_LINE + 1);

  localparam logic [CIL_W-1:0] CIL_MAX  = CIL_W'(MAX_LINE);
  localparam logic [CIL_W-1:0] CIL_OVER = CIL_W'(MAX_LINE - 2);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [23:0] PROTO_PLAIN = 24'h000204;
  localparam logic [23:0] PROTO_SUM   = 24'h004204;
  localparam logic [15:0] FUNC_READ   = 16'h0001;

  localparam logic [7:0] PCODE_FLOAT_A = 8'h18;
  localparam logic [7:0] PCODE_FLOAT_B = 8'h02;
  localparam logic [7:0] PCODE_BITS8   = 8'h01;
  localparam logic [7:0] PCODE_BITS16  = 8'h0C;

  typedef enum logic [1:0] {
    KIND_VALUE    = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_RESPONSE = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_BAD_FIELD  = 4'd1,
    ST_PROTOCOL   = 4'd2,
    ST_NOT_READ   = 4'd3,
    ST_PARAM_CODE = 4'd4,
    ST_FORMAT     = 4'd5,
    ST_CHECKSUM   = 4'd6,
    ST_DEV_STATUS = 4'd7,
    ST_NO_REQUEST = 4'd8,
    ST_UNCLASS    = 4'd9,
    ST_TOO_LONG   = 4'd10
  } status_t;

  typedef struct packed {
    kind_t       item_kind;
    logic [7:0]  unit_address;
    logic [7:0]  parameter_code;
    logic [12:0] base_index;
    logic [31:0] value_word;
    logic [5:0]  value_width;
    status_t     line_status;
  } result_t;

endpackage

>>> rtl/rlld_parser.sv
module rlld_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_char,
  output logic                 res_valid,
  output rlld_pkg::result_t    res
);

  typedef enum logic [11:0] {
    PH_FIRST     = 12'h001,
    PH_RQ_PROTO  = 12'h002,
    PH_RQ_FUNC   = 12'h004,
    PH_RQ_FORMAT = 12'h008,
    PH_RQ_COUNT  = 12'h010,
    PH_RQ_START  = 12'h020,
    PH_RQ_SUM    = 12'h040,
    PH_RQ_TAIL   = 12'h080,
    PH_RS_VALUES = 12'h100,
    PH_RS_SUM    = 12'h200,
    PH_RS_TAIL   = 12'h400,
    PH_OT_TAIL   = 12'h800
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [rlld_pkg::CIL_W-1:0]     cil_r, cil_nxt;
  logic [3:0]                     cif_r, cif_nxt;
  logic [23:0]                    facc_r, facc_nxt;
  logic [7:0]                     sum_r, sum_nxt;
  rlld_pkg::status_t              err_r, err_nxt;
  logic                           pending_r, pending_nxt;
  logic [7:0]                     unit_r, unit_nxt;
  logic                           hasck_r, hasck_nxt;
  logic [7:0]                     code_r, code_nxt;
  logic [2:0]                     bpv_r, bpv_nxt;
  logic                           bits_r, bits_nxt;
  logic [7:0]                     count_r, count_nxt;
  logic [7:0]                     start_r, start_nxt;
  logic [7:0]                     vd_r, vd_nxt;
  logic [2:0]                     bd_r, bd_nxt;
  logic [31:0]                    vacc_r, vacc_nxt;

  function automatic rlld_pkg::kind_t kind_of(phase_t ph);
    rlld_pkg::kind_t k;
    unique case (ph)
      PH_RQ_PROTO, PH_RQ_FUNC, PH_RQ_FORMAT, PH_RQ_COUNT,
      PH_RQ_START, PH_RQ_SUM, PH_RQ_TAIL:  k = rlld_pkg::KIND_REQUEST;
      PH_RS_VALUES, PH_RS_SUM, PH_RS_TAIL: k = rlld_pkg::KIND_RESPONSE;
      default:                             k = rlld_pkg::KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic phase_t tail_of(phase_t ph);
    phase_t t;
    unique case (kind_of(ph))
      rlld_pkg::KIND_REQUEST:  t = PH_RQ_TAIL;
      rlld_pkg::KIND_RESPONSE: t = PH_RS_TAIL;
      default:                 t = PH_OT_TAIL;
    endcase
    return t;
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  always_comb begin
    logic [rlld_pkg::CIL_W-1:0] pos;
    logic                       over;
    logic [4:0]                 hx;
    logic [3:0]                 n;
    logic [23:0]                v;
    logic [7:0]                 facc8;
    logic [31:0]                vacc_new;
    logic [2:0]                 bd_new;
    logic [7:0]                 vd_new;
    logic [5:0]                 w;
    rlld_pkg::status_t          st;
    rlld_pkg::kind_t            kind;

    phase_nxt   = phase_r;
    cil_nxt     = cil_r;
    cif_nxt     = cif_r;
    facc_nxt    = facc_r;
    sum_nxt     = sum_r;
    err_nxt     = err_r;
    pending_nxt = pending_r;
    unit_nxt    = unit_r;
    hasck_nxt   = hasck_r;
    code_nxt    = code_r;
    bpv_nxt     = bpv_r;
    bits_nxt    = bits_r;
    count_nxt   = count_r;
    start_nxt   = start_r;
    vd_nxt      = vd_r;
    bd_nxt      = bd_r;
    vacc_nxt    = vacc_r;
    res_valid   = 1'b0;
    res         = '0;

    pos      = cil_r;
    over     = (cil_r >= rlld_pkg::CIL_OVER);
    hx       = hex_of(rx_char);
    n        = cif_r;
    v        = facc_r;
    facc8    = {facc_r[3:0], hx[3:0]};
    vacc_new = {vacc_r[23:0], facc_r[7:0]};
    bd_new   = bd_r + 3'd1;
    vd_new   = vd_r + 8'd1;
    w        = bits_r ? {bpv_r, 3'b000} : 6'd1;
    kind     = kind_of(phase_r);
    st       = rlld_pkg::ST_OK;

    if (step) begin
      if (cil_r < rlld_pkg::CIL_MAX) begin
        cil_nxt = cil_r + 1'b1;
      end

      if (rx_char == rlld_pkg::CH_LF) begin
        if (over) begin
          st = rlld_pkg::ST_TOO_LONG;
        end else if (phase_r == PH_FIRST) begin
          st = rlld_pkg::ST_UNCLASS;
        end else if (phase_r == PH_RQ_SUM || phase_r == PH_RS_SUM) begin
          st = rlld_pkg::ST_CHECKSUM;
        end else if (phase_r == PH_RQ_TAIL || phase_r == PH_RS_TAIL ||
                     phase_r == PH_OT_TAIL) begin
          st = err_r;
        end else begin
          st = rlld_pkg::ST_BAD_FIELD;
        end
        if (kind == rlld_pkg::KIND_REQUEST && st == rlld_pkg::ST_OK) begin
          pending_nxt = 1'b1;
        end
        res_valid       = 1'b1;
        res.item_kind   = kind;
        res.line_status = st;
        if (st == rlld_pkg::ST_OK && kind != rlld_pkg::KIND_OTHER) begin
          res.unit_address   = unit_r;
          res.parameter_code = code_r;
          res.base_index     = 13'(start_r);
        end
        phase_nxt = PH_FIRST;
        cil_nxt   = '0;
        cif_nxt   = '0;
        facc_nxt  = '0;
        sum_nxt   = '0;
        err_nxt   = rlld_pkg::ST_OK;
      end else if (over) begin
        err_nxt   = rlld_pkg::ST_TOO_LONG;
        phase_nxt = tail_of(phase_r);
      end else begin
        if (phase_r != PH_RQ_SUM && phase_r != PH_RS_SUM) begin
          sum_nxt = sum_r + rx_char;
        end

        unique case (phase_r)
          PH_RQ_SUM, PH_RS_SUM: begin
            if (!hx[4]) begin
              err_nxt   = rlld_pkg::ST_CHECKSUM;
              phase_nxt = tail_of(phase_r);
            end else begin
              facc_nxt = 24'(facc8);
              cif_nxt  = cif_r + 4'd1;
              if (cif_r >= 4'd1) begin
                if (facc8 != sum_r) begin
                  err_nxt   = rlld_pkg::ST_CHECKSUM;
                  phase_nxt = tail_of(phase_r);
                end else begin
                  err_nxt   = rlld_pkg::ST_OK;
                  phase_nxt = (phase_r == PH_RQ_SUM) ? PH_RQ_TAIL : PH_RS_TAIL;
                end
              end
            end
          end

          PH_FIRST, PH_RQ_PROTO, PH_RQ_FUNC, PH_RQ_FORMAT, PH_RQ_COUNT,
          PH_RQ_START, PH_RS_VALUES: begin
            if (rx_char == rlld_pkg::CH_COMMA) begin
              // end of field
              cif_nxt  = '0;
              facc_nxt = '0;
              unique case (phase_r)
                PH_FIRST: begin
                  if (pos == rlld_pkg::CIL_W'(2)) begin
                    pending_nxt = 1'b0;
                    if (n != 4'd2) begin
                      err_nxt   = rlld_pkg::ST_BAD_FIELD;
                      phase_nxt = PH_RQ_TAIL;
                    end else begin
                      unit_nxt  = v[7:0];
                      phase_nxt = PH_RQ_PROTO;
                    end
                  end else if (pos == rlld_pkg::CIL_W'(6)) begin
                    if (!pending_r) begin
                      err_nxt   = rlld_pkg::ST_NO_REQUEST;
                      phase_nxt = PH_RS_TAIL;
                    end else if (n != 4'd6) begin
                      err_nxt   = rlld_pkg::ST_BAD_FIELD;
                      phase_nxt = PH_RS_TAIL;
                    end else begin
                      pending_nxt = 1'b0;
                      if (v != 24'd1) begin
                        err_nxt   = rlld_pkg::ST_DEV_STATUS;
                        phase_nxt = PH_RS_TAIL;
                      end else begin
                        vd_nxt   = '0;
                        bd_nxt   = '0;
                        vacc_nxt = '0;
                        if (count_r == 8'd0) begin
                          phase_nxt = hasck_r ? PH_RS_SUM : PH_RS_TAIL;
                        end else begin
                          phase_nxt = PH_RS_VALUES;
                        end
                      end
                    end
                  end else begin
                    err_nxt   = rlld_pkg::ST_UNCLASS;
                    phase_nxt = PH_OT_TAIL;
                  end
                end

                PH_RQ_PROTO: begin
                  if (n != 4'd4) begin
                    err_nxt   = rlld_pkg::ST_BAD_FIELD;
                    phase_nxt = PH_RQ_TAIL;
                  end else if (v == rlld_pkg::PROTO_PLAIN) begin
                    hasck_nxt = 1'b0;
                    phase_nxt = PH_RQ_FUNC;
                  end else if (v == rlld_pkg::PROTO_SUM) begin
                    hasck_nxt = 1'b1;
                    phase_nxt = PH_RQ_FUNC;
                  end else begin
                    err_nxt   = rlld_pkg::ST_PROTOCOL;
                    phase_nxt = PH_RQ_TAIL;
                  end
                end

                PH_RQ_FUNC: begin
                  if (n != 4'd4) begin
                    err_nxt   = rlld_pkg::ST_BAD_FIELD;
                    phase_nxt = PH_RQ_TAIL;
                  end else if (v[23:8] != rlld_pkg::FUNC_READ) begin
                    err_nxt   = rlld_pkg::ST_NOT_READ;
                    phase_nxt = PH_RQ_TAIL;
                  end else begin
                    code_nxt  = v[7:0];
                    phase_nxt = PH_RQ_FORMAT;
                    if (v[7:0] == rlld_pkg::PCODE_FLOAT_A ||
                        v[7:0] == rlld_pkg::PCODE_FLOAT_B) begin
                      bits_nxt = 1'b0;
                      bpv_nxt  = 3'd4;
                    end else if (v[7:0] == rlld_pkg::PCODE_BITS8) begin
                      bits_nxt = 1'b1;
                      bpv_nxt  = 3'd1;
                    end else if (v[7:0] == rlld_pkg::PCODE_BITS16) begin
                      bits_nxt = 1'b1;
                      bpv_nxt  = 3'd2;
                    end else begin
                      err_nxt   = rlld_pkg::ST_PARAM_CODE;
                      phase_nxt = PH_RQ_TAIL;
                    end
                  end
                end

                PH_RQ_FORMAT: begin
                  if (n != 4'd1) begin
                    err_nxt   = rlld_pkg::ST_BAD_FIELD;
                    phase_nxt = PH_RQ_TAIL;
                  end else if (v != 24'd0) begin
                    err_nxt   = rlld_pkg::ST_FORMAT;
                    phase_nxt = PH_RQ_TAIL;
                  end else begin
                    phase_nxt = PH_RQ_COUNT;
                  end
                end

                PH_RQ_COUNT: begin
                  if (n != 4'd2) begin
                    err_nxt   = rlld_pkg::ST_BAD_FIELD;
                    phase_nxt = PH_RQ_TAIL;
                  end else begin
                    count_nxt = v[7:0];
                    phase_nxt = PH_RQ_START;
                  end
                end

                PH_RQ_START: begin
                  if (n != 4'd2) begin
                    err_nxt   = rlld_pkg::ST_BAD_FIELD;
                    phase_nxt = PH_RQ_TAIL;
                  end else begin
                    start_nxt = v[7:0];
                    phase_nxt = hasck_r ? PH_RQ_SUM : PH_RQ_TAIL;
                  end
                end

                PH_RS_VALUES: begin
                  if (n != 4'd2) begin
                    err_nxt   = rlld_pkg::ST_BAD_FIELD;
                    phase_nxt = PH_RS_TAIL;
                  end else if (bd_new >= bpv_r) begin
                    res_valid          = 1'b1;
                    res.item_kind      = rlld_pkg::KIND_VALUE;
                    res.unit_address   = unit_r;
                    res.parameter_code = code_r;
                    res.base_index     = 13'(start_r) + 13'(vd_r) * 13'(w);
                    res.value_word     = vacc_new;
                    res.value_width    = w;
                    res.line_status    = rlld_pkg::ST_OK;
                    vd_nxt             = vd_new;
                    bd_nxt             = '0;
                    vacc_nxt           = '0;
                    if (vd_new >= count_r) begin
                      phase_nxt = hasck_r ? PH_RS_SUM : PH_RS_TAIL;
                    end
                  end else begin
                    bd_nxt   = bd_new;
                    vacc_nxt = vacc_new;
                  end
                end

                default: ;
              endcase
            end else if (!hx[4]) begin
              cif_nxt = 4'd15;   // poisons the field length
            end else if (cif_r < 4'd15) begin
              cif_nxt  = cif_r + 4'd1;
              facc_nxt = {facc_r[19:0], hx[3:0]};
            end
          end

          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIRST;
      cil_r     <= '0;
      cif_r     <= '0;
      facc_r    <= '0;
      sum_r     <= '0;
      err_r     <= rlld_pkg::ST_OK;
      pending_r <= 1'b0;
      unit_r    <= '0;
      hasck_r   <= 1'b0;
      code_r    <= '0;
      bpv_r     <= '0;
      bits_r    <= 1'b0;
      count_r   <= '0;
      start_r   <= '0;
      vd_r      <= '0;
      bd_r      <= '0;
      vacc_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      cil_r     <= cil_nxt;
      cif_r     <= cif_nxt;
      facc_r    <= facc_nxt;
      sum_r     <= sum_nxt;
      err_r     <= err_nxt;
      pending_r <= pending_nxt;
      unit_r    <= unit_nxt;
      hasck_r   <= hasck_nxt;
      code_r    <= code_nxt;
      bpv_r     <= bpv_nxt;
      bits_r    <= bits_nxt;
      count_r   <= count_nxt;
      start_r   <= start_nxt;
      vd_r      <= vd_nxt;
      bd_r      <= bd_nxt;
      vacc_r    <= vacc_nxt;
    end
  end

endmodule

>>> rtl/rlld_out_reg.sv
module rlld_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  rlld_pkg::result_t    res_in,
  input  logic                 out_ready,
  output logic                 space,
  output logic                 out_valid,
  output rlld_pkg::result_t    res_out
);

  logic              valid_r, valid_nxt;
  rlld_pkg::result_t res_r;

  // slot is free when empty or drained this cycle
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

>>> rtl/recorder_link_line_decoder_top.sv
// Line decoder for a sniffed recorder link.
// Input channel: one received character per item (in_rx_char); LF ends a line.
// Result channel: value words emitted while a response is parsed, and one
// verdict per line at its LF. Values are provisional: drop them when the
// verdict that follows carries a nonzero line status.
// Both channels use valid/ready; an item moves when valid and ready are high.
// A character taken into the input register is parsed once the result register
// has space, and its result, if any, is loaded into that register.
// Throughput: one character per cycle while the result register has space,
// set by the single parser state update per character; most give no result.
// Reset (rst_n low, synchronous) starts a new line, forgets any request and
// empties both registers.
// A stalled receiver holds the result register; the parser then stops and the
// input register holds its character, so in_ready drops after one more item.
module recorder_link_line_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_unit_address,
  output logic [7:0]  out_parameter_code,
  output logic [12:0] out_base_index,
  output logic [31:0] out_value_word,
  output logic [5:0]  out_value_width,
  output logic [3:0]  out_line_status
);

  `include "recorder_link_line_decoder_top_assert.svh"

  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_char_r;
  logic              step;
  logic              space;
  logic              res_valid;
  rlld_pkg::result_t res;
  rlld_pkg::result_t res_out;

  assign step     = s1_valid_r && space;
  assign in_ready = !s1_valid_r || step;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_rx_char;
    end
  end

  rlld_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_char   (s1_char_r),
    .res_valid (res_valid),
    .res       (res)
  );

  rlld_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .space     (space),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_item_kind      = res_out.item_kind;
  assign out_unit_address   = res_out.unit_address;
  assign out_parameter_code = res_out.parameter_code;
  assign out_base_index     = res_out.base_index;
  assign out_value_word     = res_out.value_word;
  assign out_value_width    = res_out.value_width;
  assign out_line_status    = res_out.line_status;

  `RLLD_ASSERT_SAME(a_value_ok,
    out_valid && out_item_kind == rlld_pkg::KIND_VALUE,
    out_line_status == rlld_pkg::ST_OK &&
      (out_value_width == 6'd1 || out_value_width == 6'd8 || out_value_width == 6'd16),
    "value item with bad status or width")
  `RLLD_ASSERT_SAME(a_verdict_empty,
    out_valid && out_item_kind != rlld_pkg::KIND_VALUE,
    out_value_word == 32'd0 && out_value_width == 6'd0,
    "verdict carries a value")
  `RLLD_ASSERT_SAME(a_failed_verdict_zero,
    out_valid && out_item_kind != rlld_pkg::KIND_VALUE &&
      out_line_status != rlld_pkg::ST_OK,
    out_unit_address == 8'd0 && out_parameter_code == 8'd0 && out_base_index == 13'd0,
    "failed verdict carries request fields")
  `RLLD_ASSERT_NEXT(a_stall_holds_char,
    s1_valid_r && out_valid && !out_ready,
    s1_valid_r && $stable(s1_char_r),
    "pending character lost during output stall")

endmodule
